[rtl/core/cidf_pkg.sv]
// ----------------------------------------------------------------------------
// CAN ID filter package
// Shared widths, configuration register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cidf_pkg;

	// Field widths of the item and result beats.
	localparam int ID_W       = 11;
	localparam int FRAME_ID_W = 29;
	localparam int LEN_W      = 4;
	localparam int DATA_W     = 64;
	localparam int TIME_W     = 64;
	localparam int TOTAL_W    = 32;
	localparam int MAXF_W     = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 44;

	// Payload bytes per frame and filter IDs packed into one ID register.
	localparam int MAX_BYTES    = 8;
	localparam int IDS_PER_WORD = 4;

	// Action codes of an input item.
	localparam logic ACT_FRAME   = 1'b0;
	localparam logic ACT_COLLECT = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDS_LOW      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDS_HIGH     = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // item beat taken this cycle
		logic emit_slot;   // load result register from the scanned slot
		logic emit_empty;  // load result register with the not-valid result
		logic last;        // emitted slot closes the collect
	} cidf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;    // result register can take a new beat
		logic past_end;    // scan index reached the active slot count
		logic dirty_hit;   // scanned slot is dirty
		logic more_after;  // a dirty active slot lies above the scan index
		logic quota_done;  // emitted count reached the request limit
		logic quota_last;  // one more emission reaches the request limit
	} cidf_status_t;

endpackage

`default_nettype wire

[rtl/core/can_id_filter_latest_frame_store.sv]
// A received frame never stalls the input; the next item may follow in the next cycle.
// A collect walks the active slots (filter_count capped at SLOTS) one per cycle while the
// result register is free and emits each dirty slot as it is reached, up to max_frames
// capped at SLOTS; the input stalls after the collect beat until the walk has ended.
// Results leave through a result register, one beat per cycle when not stalled.
// Reset clears the configuration, dirty marks and frame counter at once; no clearing pass.
// ----------------------------------------------------------------------------
// CAN ID filter with latest-frame mailboxes
// Counts received frames, stores standard frames matching a configured ID in
// the lowest matching slot, and returns dirty slots on a collect request.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_filter_latest_frame_store #(
	parameter int SLOTS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Configuration write channel.
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [cidf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cidf_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Item channel.
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  action,
	input  wire  [cidf_pkg::FRAME_ID_W-1:0]      frame_id,
	input  wire                                  extended_flag,
	input  wire  [cidf_pkg::LEN_W-1:0]           frame_length,
	input  wire  [cidf_pkg::DATA_W-1:0]          frame_data,
	input  wire  [cidf_pkg::TIME_W-1:0]          frame_time,
	input  wire  [cidf_pkg::MAXF_W-1:0]          max_frames,
	// Result channel.
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [cidf_pkg::ID_W-1:0]            out_id,
	output logic [cidf_pkg::LEN_W-1:0]           out_length,
	output logic [cidf_pkg::DATA_W-1:0]          out_data,
	output logic [cidf_pkg::TIME_W-1:0]          out_time,
	output logic                                 frame_valid,
	output logic                                 last_result,
	output logic [cidf_pkg::TOTAL_W-1:0]         received_total
);
	import cidf_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	cidf_cmd_t        cmd;
	cidf_status_t     st;
	logic [CNT_W-1:0] scan_idx;
	logic [CNT_W-1:0] scan_cnt;

	// The user must write registers only while the block is idle; the block does not enforce it.
	assign cfg_ready = 1'b1;

	cidf_ctrl #(
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd),
		.scan_idx (scan_idx),
		.scan_cnt (scan_cnt)
	);

	cidf_dp #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.frame_id       (frame_id),
		.extended_flag  (extended_flag),
		.frame_length   (frame_length),
		.frame_data     (frame_data),
		.frame_time     (frame_time),
		.max_frames     (max_frames),
		.cmd            (cmd),
		.scan_idx       (scan_idx),
		.scan_cnt       (scan_cnt),
		.st             (st),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_id         (out_id),
		.out_length     (out_length),
		.out_data       (out_data),
		.out_time       (out_time),
		.frame_valid    (frame_valid),
		.last_result    (last_result),
		.received_total (received_total)
	);

endmodule

`default_nettype wire

[rtl/core/cidf_ctrl.sv]
// ----------------------------------------------------------------------------
// CAN ID filter controller
// Takes item beats, tells the datapath which slot to emit and when a collect
// ends, and walks the slots one per cycle while the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cidf_ctrl #(
	parameter int CNT_W = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    action,
	output logic                   in_stall,
	input  cidf_pkg::cidf_status_t st,
	output cidf_pkg::cidf_cmd_t    cmd,
	output logic [CNT_W-1:0]       scan_idx,
	output logic [CNT_W-1:0]       scan_cnt
);
	import cidf_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;

	assign scan_idx = idx_q;
	assign scan_cnt = cnt_q;

	// Items are taken only while no collect is being walked.
	assign in_stall = (state_q == ST_SCAN);

	// Commands for the current cycle.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_SCAN: begin
				if (st.out_free) begin
					if (st.past_end || st.quota_done) begin
						cmd.emit_empty = 1'b1;
					end else if (st.dirty_hit) begin
						cmd.emit_slot = 1'b1;
						cmd.last      = !st.more_after || st.quota_last;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State, scan index and emitted count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && action == ACT_COLLECT) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cmd.emit_empty) begin
						state_q <= ST_IDLE;
					end else if (cmd.emit_slot) begin
						idx_q <= idx_q + CNT_W'(1);
						cnt_q <= cnt_q + CNT_W'(1);
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end
					end else if (st.out_free) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/cidf_dp.sv]
// ----------------------------------------------------------------------------
// CAN ID filter datapath
// Holds the filter configuration, the slot mailboxes with their dirty marks,
// the frame counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cidf_dp #(
	parameter int SLOTS = 8,
	parameter int IDX_W = 3,
	parameter int CNT_W = 4
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Configuration writes.
	input  wire                                  cfg_we,
	input  wire  [cidf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cidf_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Item fields.
	input  wire                                  action,
	input  wire  [cidf_pkg::FRAME_ID_W-1:0]      frame_id,
	input  wire                                  extended_flag,
	input  wire  [cidf_pkg::LEN_W-1:0]           frame_length,
	input  wire  [cidf_pkg::DATA_W-1:0]          frame_data,
	input  wire  [cidf_pkg::TIME_W-1:0]          frame_time,
	input  wire  [cidf_pkg::MAXF_W-1:0]          max_frames,
	// Controller link.
	input  cidf_pkg::cidf_cmd_t                  cmd,
	input  wire  [CNT_W-1:0]                     scan_idx,
	input  wire  [CNT_W-1:0]                     scan_cnt,
	output cidf_pkg::cidf_status_t               st,
	// Result beat.
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [cidf_pkg::ID_W-1:0]            out_id,
	output logic [cidf_pkg::LEN_W-1:0]           out_length,
	output logic [cidf_pkg::DATA_W-1:0]          out_data,
	output logic [cidf_pkg::TIME_W-1:0]          out_time,
	output logic                                 frame_valid,
	output logic                                 last_result,
	output logic [cidf_pkg::TOTAL_W-1:0]         received_total
);
	import cidf_pkg::*;

	// Configuration registers.
	logic [MAXF_W-1:0]     count_q;
	logic [CFG_DATA_W-1:0] ids_low_q;
	logic [CFG_DATA_W-1:0] ids_high_q;

	// Slot mailboxes and marks.
	logic [LEN_W-1:0]  slot_len_q  [SLOTS];
	logic [DATA_W-1:0] slot_data_q [SLOTS];
	logic [TIME_W-1:0] slot_time_q [SLOTS];
	logic [SLOTS-1:0]  dirty_q;
	logic [TOTAL_W-1:0] frames_q;

	// Collect request limit.
	logic [CNT_W-1:0] max_q;

	// Result register.
	logic               out_valid_q;
	logic [ID_W-1:0]    out_id_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [TIME_W-1:0]  out_time_q;
	logic               out_fv_q;
	logic               out_last_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic [ID_W-1:0]   slot_id [SLOTS];
	logic [CNT_W-1:0]  n_active;
	logic [CNT_W-1:0]  maxf_clamp;
	logic [SLOTS-1:0]  hit;
	logic              found;
	logic [IDX_W-1:0]  win_idx;
	logic [LEN_W-1:0]  len_clamp;
	logic [DATA_W-1:0] data_masked;
	logic              cfg_known;
	logic              frame_take;
	logic              frame_store;
	logic [IDX_W-1:0]  rd_idx;

	// Filter IDs of each slot, four per ID register.
	for (genvar s = 0; s < SLOTS; s++) begin : g_id
		if (s < IDS_PER_WORD) begin : g_low
			assign slot_id[s] = ids_low_q[(s % IDS_PER_WORD) * ID_W +: ID_W];
		end else begin : g_high
			assign slot_id[s] = ids_high_q[(s % IDS_PER_WORD) * ID_W +: ID_W];
		end
	end

	// Active slot count and request limit, both capped at the slot count.
	assign n_active   = (count_q > MAXF_W'(SLOTS)) ? CNT_W'(SLOTS) : count_q[CNT_W-1:0];
	assign maxf_clamp = (max_frames > MAXF_W'(SLOTS)) ? CNT_W'(SLOTS)
		: max_frames[CNT_W-1:0];

	// Match the full identifier against each active slot; lowest slot wins.
	always_comb begin
		found   = 1'b0;
		win_idx = '0;
		for (int s = 0; s < SLOTS; s++) begin
			hit[s] = (CNT_W'(s) < n_active)
				&& (frame_id == {{(FRAME_ID_W-ID_W){1'b0}}, slot_id[s]});
		end
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (hit[s]) begin
				found   = 1'b1;
				win_idx = IDX_W'(s);
			end
		end
	end

	// Clamp the length and zero the bytes past it.
	assign len_clamp = (frame_length > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : frame_length;
	always_comb begin
		for (int b = 0; b < MAX_BYTES; b++) begin
			data_masked[b*8 +: 8] = (LEN_W'(b) < len_clamp) ? frame_data[b*8 +: 8] : 8'h00;
		end
	end

	assign frame_take  = cmd.accept && (action == ACT_FRAME);
	assign frame_store = frame_take && !extended_flag && found;
	assign cfg_known   = (cfg_index == CFG_FILTER_COUNT) || (cfg_index == CFG_IDS_LOW)
		|| (cfg_index == CFG_IDS_HIGH);
	assign rd_idx      = scan_idx[IDX_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ids_low_q  <= '0;
			ids_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_COUNT: count_q    <= cfg_data[MAXF_W-1:0];
				CFG_IDS_LOW:      ids_low_q  <= cfg_data;
				CFG_IDS_HIGH:     ids_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Dirty marks: cleared by any known register write, set on store,
	// cleared when the slot is emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
		end else if (cfg_we && cfg_known) begin
			dirty_q <= '0;
		end else begin
			if (frame_store) begin
				dirty_q[win_idx] <= 1'b1;
			end
			if (cmd.emit_slot) begin
				dirty_q[rd_idx] <= 1'b0;
			end
		end
	end

	// Frame counter and collect limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			max_q    <= '0;
		end else begin
			if (frame_take) begin
				frames_q <= frames_q + TOTAL_W'(1);
			end
			if (cmd.accept && action == ACT_COLLECT) begin
				max_q <= maxf_clamp;
			end
		end
	end

	// Slot mailbox write.
	always_ff @(posedge clk) begin
		if (frame_store) begin
			slot_len_q[win_idx]  <= len_clamp;
			slot_data_q[win_idx] <= data_masked;
			slot_time_q[win_idx] <= frame_time;
		end
	end

	// Scan status.
	always_comb begin
		st.more_after = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (CNT_W'(j) > scan_idx && CNT_W'(j) < n_active && dirty_q[j]) begin
				st.more_after = 1'b1;
			end
		end
		st.out_free   = !out_valid_q || !out_stall;
		st.past_end   = (scan_idx >= n_active);
		st.dirty_hit  = dirty_q[rd_idx];
		st.quota_done = (scan_cnt >= max_q);
		st.quota_last = ((scan_cnt + CNT_W'(1)) >= max_q);
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_slot || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_slot) begin
			out_id_q    <= slot_id[rd_idx];
			out_len_q   <= slot_len_q[rd_idx];
			out_data_q  <= slot_data_q[rd_idx];
			out_time_q  <= slot_time_q[rd_idx];
			out_fv_q    <= 1'b1;
			out_last_q  <= cmd.last;
			out_total_q <= frames_q;
		end else if (cmd.emit_empty) begin
			out_id_q    <= '0;
			out_len_q   <= '0;
			out_data_q  <= '0;
			out_time_q  <= '0;
			out_fv_q    <= 1'b0;
			out_last_q  <= 1'b1;
			out_total_q <= frames_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_id         = out_id_q;
	assign out_length     = out_len_q;
	assign out_data       = out_data_q;
	assign out_time       = out_time_q;
	assign frame_valid    = out_fv_q;
	assign last_result    = out_last_q;
	assign received_total = out_total_q;

`ifndef SYNTHESIS
	// A result is loaded only when the previous beat has left.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_slot || cmd.emit_empty) |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending beat");

	// Only a dirty slot is emitted, and its mark is gone afterwards.
	a_emit_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_slot |-> dirty_q[rd_idx])
		else $error("emitted slot was not dirty");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_slot |=> !dirty_q[$past(rd_idx)])
		else $error("emitted slot still dirty");

	// Every received frame advances the counter by exactly one.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take |=> (frames_q == $past(frames_q) + TOTAL_W'(1)))
		else $error("frame counter did not advance");
`endif

endmodule

`default_nettype wire

[bench/tb_can_id_filter_latest_frame_store.sv]
// ----------------------------------------------------------------------------
// CAN ID filter latest-frame store testbench
// Drives received frames and collect requests through the item channel and
// rewrites the filter registers between phases. A behavioral copy of the
// slot store predicts every result beat, which is checked field by field as
// it leaves the block. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_can_id_filter_latest_frame_store;

	import cidf_pkg::*;

	localparam int SLOTS          = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 23;

	// Index past the end of the register list; writes to it are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic                  act;
		logic [FRAME_ID_W-1:0] id;
		logic                  ext;
		logic [LEN_W-1:0]      len;
		logic [DATA_W-1:0]     data;
		logic [TIME_W-1:0]     stamp;
		logic [MAXF_W-1:0]     maxf;
	} can_item_t;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [LEN_W-1:0]   len;
		logic [DATA_W-1:0]  data;
		logic [TIME_W-1:0]  stamp;
		logic               fvalid;
		logic               last;
		logic [TOTAL_W-1:0] total;
	} collect_beat_t;

	typedef enum {RX_OPEN, RX_SPARSE, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [FRAME_ID_W-1:0] frame_id;
	logic                  extended_flag;
	logic [LEN_W-1:0]      frame_length;
	logic [DATA_W-1:0]     frame_data;
	logic [TIME_W-1:0]     frame_time;
	logic [MAXF_W-1:0]     max_frames;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ID_W-1:0]       out_id;
	logic [LEN_W-1:0]      out_length;
	logic [DATA_W-1:0]     out_data;
	logic [TIME_W-1:0]     out_time;
	logic                  frame_valid;
	logic                  last_result;
	logic [TOTAL_W-1:0]    received_total;

	// Shadow copy of the filter registers and the slot store.
	logic [3:0]         shadow_count;
	logic [43:0]        shadow_ids_low;
	logic [43:0]        shadow_ids_high;
	logic [LEN_W-1:0]   slot_len_q [SLOTS];
	logic [DATA_W-1:0]  slot_data_q [SLOTS];
	logic [TIME_W-1:0]  slot_stamp_q [SLOTS];
	bit                 slot_dirty_q [SLOTS];
	logic [TOTAL_W-1:0] frames_seen;

	collect_beat_t expected_beats [$];
	collect_beat_t want_beat;
	int            errors = 0;
	int            burst_left = 0;
	int            idle_cycles = 0;
	int            rx_left = 0;
	rx_mode_t      rx_mode = RX_OPEN;

	can_id_filter_latest_frame_store #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.frame_id      (frame_id),
		.extended_flag (extended_flag),
		.frame_length  (frame_length),
		.frame_data    (frame_data),
		.frame_time    (frame_time),
		.max_frames    (max_frames),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_id        (out_id),
		.out_length    (out_length),
		.out_data      (out_data),
		.out_time      (out_time),
		.frame_valid   (frame_valid),
		.last_result   (last_result),
		.received_total(received_total)
	);

	// Free-running clock, period 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Filter ID held for one slot in the shadow registers.
	function automatic logic [ID_W-1:0] filter_id_of(int s);
		logic [43:0] word;
		word = (s < IDS_PER_WORD) ? shadow_ids_low : shadow_ids_high;
		return word[(s % IDS_PER_WORD) * ID_W +: ID_W];
	endfunction

	function automatic void clear_slots();
		for (int s = 0; s < SLOTS; s++) begin
			slot_len_q[s]   = '0;
			slot_data_q[s]  = '0;
			slot_stamp_q[s] = '0;
			slot_dirty_q[s] = 1'b0;
		end
	endfunction

	// Update the slot store for one accepted item and queue the beats it causes.
	function automatic void predict_item(can_item_t it);
		collect_beat_t beats [SLOTS];
		int            active;
		int            limit;
		int            emitted;
		bit            stored;
		logic [3:0]    clamped;
		logic [63:0]   keep;
		collect_beat_t empty;
		active = (shadow_count > SLOTS) ? SLOTS : int'(shadow_count);
		if (it.act == ACT_FRAME) begin
			frames_seen = frames_seen + 1'b1;
			stored = 1'b0;
			if (!it.ext) begin
				for (int s = 0; s < active; s++) begin
					if (!stored && it.id == filter_id_of(s)) begin
						clamped = (it.len > MAX_BYTES) ? 4'(MAX_BYTES) : it.len;
						keep = (clamped >= 8) ? '1 : ((64'd1 << (8 * clamped)) - 64'd1);
						slot_len_q[s]   = clamped;
						slot_data_q[s]  = it.data & keep;
						slot_stamp_q[s] = it.stamp;
						slot_dirty_q[s] = 1'b1;
						stored = 1'b1;
					end
				end
			end
			return;
		end
		limit = (it.maxf > SLOTS) ? SLOTS : int'(it.maxf);
		emitted = 0;
		for (int s = 0; s < active; s++) begin
			if (emitted < limit && slot_dirty_q[s]) begin
				beats[emitted].id     = filter_id_of(s);
				beats[emitted].len    = slot_len_q[s];
				beats[emitted].data   = slot_data_q[s];
				beats[emitted].stamp  = slot_stamp_q[s];
				beats[emitted].fvalid = 1'b1;
				beats[emitted].last   = 1'b0;
				beats[emitted].total  = frames_seen;
				slot_dirty_q[s] = 1'b0;
				emitted++;
			end
		end
		if (emitted == 0) begin
			empty.id     = '0;
			empty.len    = '0;
			empty.data   = '0;
			empty.stamp  = '0;
			empty.fvalid = 1'b0;
			empty.last   = 1'b1;
			empty.total  = frames_seen;
			expected_beats.push_back(empty);
		end else begin
			beats[emitted - 1].last = 1'b1;
			for (int i = 0; i < emitted; i++)
				expected_beats.push_back(beats[i]);
		end
	endfunction

	// Item builders; fields the block ignores for the action are random.
	function automatic can_item_t frame_item(logic [FRAME_ID_W-1:0] id, logic ext,
			logic [LEN_W-1:0] len, logic [DATA_W-1:0] data, logic [TIME_W-1:0] stamp);
		can_item_t it;
		it.act   = ACT_FRAME;
		it.id    = id;
		it.ext   = ext;
		it.len   = len;
		it.data  = data;
		it.stamp = stamp;
		it.maxf  = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic can_item_t collect_item(logic [MAXF_W-1:0] maxf);
		can_item_t it;
		it.act   = ACT_COLLECT;
		it.id    = 29'($urandom);
		it.ext   = 1'($urandom);
		it.len   = 4'($urandom);
		it.data  = {$urandom, $urandom};
		it.stamp = {$urandom, $urandom};
		it.maxf  = maxf;
		return it;
	endfunction

	// Mostly frames aimed at configured IDs, with some strays and collects.
	function automatic can_item_t random_item();
		int                    sel;
		logic [FRAME_ID_W-1:0] id;
		logic [MAXF_W-1:0]     maxf;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			id = 29'(filter_id_of($urandom_range(0, SLOTS - 1)));
		else if (sel < 8)
			id = 29'($urandom_range(0, 2047));
		else
			id = 29'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			maxf = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 8));
			return collect_item(maxf);
		end
		return frame_item(id, $urandom_range(0, 6) == 0, 4'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	// Offer one item beat; the sender may idle between bursts of random length.
	task automatic send_item(can_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		action        <= it.act;
		frame_id      <= it.id;
		extended_flag <= it.ext;
		frame_length  <= it.len;
		frame_data    <= it.data;
		frame_time    <= it.stamp;
		max_frames    <= it.maxf;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_item(it);
		burst_left--;
	endtask

	// Write one register; more keeps valid high for a following write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
			bit more);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_FILTER_COUNT: begin
				shadow_count = value[3:0];
				clear_slots();
			end
			CFG_IDS_LOW: begin
				shadow_ids_low = value;
				clear_slots();
			end
			CFG_IDS_HIGH: begin
				shadow_ids_high = value;
				clear_slots();
			end
			default: begin
			end
		endcase
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	// Count carries random upper bits, which the block must ignore.
	task automatic configure(logic [3:0] cnt, logic [43:0] ids_low, logic [43:0] ids_high);
		logic [CFG_DATA_W-1:0] count_word;
		count_word = CFG_DATA_W'({$urandom, $urandom});
		count_word[3:0] = cnt;
		write_reg(CFG_FILTER_COUNT, count_word, 1'b1);
		write_reg(CFG_IDS_LOW, ids_low, 1'b1);
		write_reg(CFG_IDS_HIGH, ids_high, 1'b0);
	endtask

	// Stop sending, wait for every expected beat, then let a slot walk finish.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Collects and frames before any filter is configured.
	task automatic test_empty_after_reset();
		send_item(collect_item(4'd8));
		send_item(frame_item(29'd0, 1'b0, 4'd8, '1, '1));
		send_item(collect_item(4'd8));
	endtask

	// Matching, duplicate IDs, length clamping, strays and collect limits.
	task automatic test_match_and_clamp();
		settle();
		configure(4'd8, {11'h123, 11'h123, 11'h7ff, 11'h000},
			{11'h400, 11'h001, 11'h2aa, 11'h555});
		send_item(frame_item(29'h000, 1'b0, 4'd0, '1, '0));
		send_item(frame_item(29'h7ff, 1'b0, 4'd8, {$urandom, $urandom}, '1));
		send_item(frame_item(29'h123, 1'b0, 4'd15, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(frame_item(29'h400, 1'b0, 4'd3, '1, {$urandom, $urandom}));
		// Extended frames and standard IDs wider than 11 bits are only counted.
		send_item(frame_item(29'h555, 1'b1, 4'd4, '1, '1));
		send_item(frame_item(29'hd55, 1'b0, 4'd4, '1, '1));
		send_item(frame_item(29'h1fffffff, 1'b1, 4'd8, '1, '1));
		send_item(collect_item(4'd0));
		send_item(collect_item(4'd2));
		send_item(frame_item(29'h2aa, 1'b0, 4'd7, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(collect_item(4'd15));
		send_item(collect_item(4'd8));
	endtask

	// A write to an index past the list leaves dirty slots alone.
	task automatic test_unused_index();
		send_item(frame_item(29'h001, 1'b0, 4'd1, {$urandom, $urandom}, {$urandom, $urandom}));
		settle();
		write_reg(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}), 1'b0);
		send_item(collect_item(4'd1));
	endtask

	// Register writes drop dirty slots; the count bounds the active slots.
	task automatic test_count_and_clear();
		send_item(frame_item(29'h555, 1'b0, 4'd5, {$urandom, $urandom}, {$urandom, $urandom}));
		settle();
		write_reg(CFG_FILTER_COUNT, 44'hfff_ffff_ffff, 1'b0);
		send_item(collect_item(4'd8));
		send_item(frame_item(29'h400, 1'b0, 4'd9, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(collect_item(4'd9));
		settle();
		write_reg(CFG_FILTER_COUNT, 44'd3, 1'b0);
		send_item(frame_item(29'h555, 1'b0, 4'd2, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(frame_item(29'h123, 1'b0, 4'd6, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(collect_item(4'd8));
		settle();
		write_reg(CFG_FILTER_COUNT, 44'd0, 1'b0);
		send_item(frame_item(29'h000, 1'b0, 4'd8, {$urandom, $urandom}, {$urandom, $urandom}));
		send_item(collect_item(4'd8));
	endtask

	// Random traffic over several filter settings, the extremes among them.
	task automatic test_random_traffic();
		logic [ID_W-1:0] ids [SLOTS];
		logic [3:0]      cnt;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			for (int s = 0; s < SLOTS; s++) begin
				case (p % 4)
					0: ids[s] = '1;
					1: ids[s] = ($urandom_range(0, 1) == 0) ? 11'h3c3 : 11'($urandom);
					2: ids[s] = 11'($urandom);
					default: ids[s] = '0;
				endcase
			end
			cnt = (p % 2 == 0) ? 4'd8 : 4'($urandom_range(0, 15));
			configure(cnt, {ids[3], ids[2], ids[1], ids[0]}, {ids[7], ids[6], ids[5], ids[4]});
			repeat (PHASE_ITEMS) send_item(random_item());
			send_item(collect_item(4'd8));
		end
	endtask

	// Compare one result field against its prediction.
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Every result beat is matched against the oldest predicted beat.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat expected none, actual id %h valid %b", $time,
					out_id, frame_valid);
			end else begin
				want_beat = expected_beats.pop_front();
				check_field("out_id", 64'(want_beat.id), 64'(out_id));
				check_field("out_length", 64'(want_beat.len), 64'(out_length));
				check_field("out_data", want_beat.data, out_data);
				check_field("out_time", want_beat.stamp, out_time);
				check_field("frame_valid", 64'(want_beat.fvalid), 64'(frame_valid));
				check_field("last_result", 64'(want_beat.last), 64'(last_result));
				check_field("received_total", 64'(want_beat.total), 64'(received_total));
			end
		end
	end

	// Receiver stall pattern: windows of open, sparse, heavy or periodic stall.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 40);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   out_stall <= 1'b0;
			RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
			default:   out_stall <= rx_left[1];
		endcase
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Reset once, run the tests in turn, then report.
	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = ACT_FRAME;
		frame_id      = '0;
		extended_flag = 1'b0;
		frame_length  = '0;
		frame_data    = '0;
		frame_time    = '0;
		max_frames    = '0;
		shadow_count    = '0;
		shadow_ids_low  = '0;
		shadow_ids_high = '0;
		frames_seen     = '0;
		clear_slots();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_after_reset();
		test_match_and_clamp();
		test_unused_index();
		test_count_and_clear();
		test_random_traffic();
		settle();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
rtl/core/cidf_pkg.sv
rtl/core/cidf_ctrl.sv
rtl/core/cidf_dp.sv
rtl/core/can_id_filter_latest_frame_store.sv
bench/tb_can_id_filter_latest_frame_store.sv
